FILE: hdl/swce_pkg.sv
// ----------------------------------------------------------------------------
// swce_pkg
// Shared types and constants of the stop-and-wait confirm engine: item codes,
// action codes, configuration layout and the result record.
// ----------------------------------------------------------------------------
package swce_pkg;

	localparam int MSG_W   = 16;
	localparam int FTYPE_W = 8;
	localparam int KIND_W  = 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [KIND_W-1:0] KIND_SEND  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FRAME = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

	localparam logic [FTYPE_W-1:0] FT_CONFIRM = 8'd0;

	localparam logic REG_MAX_RETRIES = 1'b0;
	localparam logic REG_TIMEOUT     = 1'b1;

	localparam logic [7:0]  MAX_RETRIES_RST = 8'd3;
	localparam logic [15:0] TIMEOUT_RST     = 16'd1000;

	typedef enum logic [2:0] {
		ACT_TX_NEW    = 3'd0,
		ACT_RETX      = 3'd1,
		ACT_DELIVER   = 3'd2,
		ACT_DROP      = 3'd3,
		ACT_CONFIRMED = 3'd4,
		ACT_FAILED    = 3'd5,
		ACT_BUSY      = 3'd6
	} action_t;

	typedef struct packed {
		logic [7:0]  max_retries;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		action_t          action;
		logic [MSG_W-1:0] msg_id;
	} res_t;

endpackage

FILE: hdl/swce_if.sv
// ----------------------------------------------------------------------------
// swce_req_if / swce_evt_if
// Valid/ready channels of the engine: incoming request items and outgoing
// action items.
// ----------------------------------------------------------------------------
interface swce_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  frame_type;
	logic [15:0] frame_id;

	modport source (output valid, kind, frame_type, frame_id, input ready);
	modport sink (input valid, kind, frame_type, frame_id, output ready);
endinterface

interface swce_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [15:0] msg_id;

	modport source (output valid, action, msg_id, input ready);
	modport sink (input valid, action, msg_id, output ready);
endinterface

FILE: hdl/swce_ram.sv
// ----------------------------------------------------------------------------
// swce_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module swce_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/swce_cfg.sv
// ----------------------------------------------------------------------------
// swce_cfg
// APB register file holding the retry limit and the confirm timeout.
// ----------------------------------------------------------------------------
module swce_cfg
	import swce_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_retries   <= MAX_RETRIES_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_MAX_RETRIES: cfg_q.max_retries   <= pwdata[7:0];
				REG_TIMEOUT:     cfg_q.timeout_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_MAX_RETRIES: prdata = {24'd0, cfg_q.max_retries};
			REG_TIMEOUT:     prdata = {16'd0, cfg_q.timeout_ticks};
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/swce_arq.sv
// ----------------------------------------------------------------------------
// swce_arq
// Session state of the engine (next id, outstanding id, attempts, wait timer)
// and the decision for one item, given the seen bit read from the bitmap.
// ----------------------------------------------------------------------------
module swce_arq
	import swce_pkg::*;
#(
	parameter int ID_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               fire,
	input  logic [KIND_W-1:0]  kind,
	input  logic [FTYPE_W-1:0] frame_type,
	input  logic [ID_BITS-1:0] frame_id,
	input  logic               seen,
	output res_t               res,
	output logic               wr_en,
	output logic [ID_BITS-1:0] wr_addr
);

	logic [ID_BITS-1:0] next_id_q, next_id_d;
	logic               waiting_q, waiting_d;
	logic [ID_BITS-1:0] out_id_q, out_id_d;
	logic [7:0]         attempt_q, attempt_d;
	logic [15:0]        timer_q, timer_d;
	logic [15:0]        timer_inc;
	logic               do_retry;
	res_t               res_c;
	logic               wr_c;

	assign timer_inc = (timer_q != 16'hFFFF) ? timer_q + 16'd1 : timer_q;

	always_comb begin
		next_id_d = next_id_q;
		waiting_d = waiting_q;
		out_id_d  = out_id_q;
		attempt_d = attempt_q;
		timer_d   = timer_q;
		do_retry  = 1'b0;
		wr_c      = 1'b0;
		res_c.valid  = 1'b0;
		res_c.action = ACT_TX_NEW;
		res_c.msg_id = MSG_W'(out_id_q);
		case (kind)
			KIND_SEND: begin
				res_c.valid = 1'b1;
				if (waiting_q) begin
					res_c.action = ACT_BUSY;
				end else begin
					res_c.action = ACT_TX_NEW;
					res_c.msg_id = MSG_W'(next_id_q);
					next_id_d    = next_id_q + ID_BITS'(1);
					waiting_d    = 1'b1;
					out_id_d     = next_id_q;
					attempt_d    = 8'd0;
					timer_d      = 16'd0;
				end
			end
			KIND_FRAME: begin
				if (waiting_q) begin
					if (frame_type == FT_CONFIRM && frame_id == out_id_q) begin
						res_c.valid  = 1'b1;
						res_c.action = ACT_CONFIRMED;
						waiting_d    = 1'b0;
						timer_d      = 16'd0;
					end else begin
						do_retry = 1'b1;
					end
				end else if (frame_type != FT_CONFIRM) begin
					res_c.valid  = 1'b1;
					res_c.msg_id = MSG_W'(frame_id);
					if (seen) begin
						res_c.action = ACT_DROP;
					end else begin
						res_c.action = ACT_DELIVER;
						wr_c         = 1'b1;
					end
				end
			end
			KIND_TICK: begin
				if (waiting_q) begin
					timer_d = timer_inc;
					if (timer_inc >= cfg.timeout_ticks) begin
						do_retry = 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (do_retry) begin
			res_c.valid = 1'b1;
			timer_d     = 16'd0;
			if (attempt_q >= cfg.max_retries) begin
				res_c.action = ACT_FAILED;
				waiting_d    = 1'b0;
			end else begin
				res_c.action = ACT_RETX;
				attempt_d    = attempt_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= ID_BITS'(1);
			waiting_q <= 1'b0;
			out_id_q  <= '0;
			attempt_q <= 8'd0;
			timer_q   <= 16'd0;
		end else if (fire) begin
			next_id_q <= next_id_d;
			waiting_q <= waiting_d;
			out_id_q  <= out_id_d;
			attempt_q <= attempt_d;
			timer_q   <= timer_d;
		end
	end

	always_comb begin
		res       = res_c;
		res.valid = res_c.valid && fire;
	end

	assign wr_en   = wr_c && fire;
	assign wr_addr = frame_id;

	a_new_starts_wait: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.action == ACT_TX_NEW |=> waiting_q)
		else $error("wait not started after new transmission");

	a_confirm_ends_wait: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.action == ACT_CONFIRMED || res.action == ACT_FAILED)
		|=> !waiting_q)
		else $error("wait still open after confirm or failure");

	a_id_advance: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.action == ACT_TX_NEW
		|=> next_id_q == $past(next_id_q) + ID_BITS'(1))
		else $error("next id did not advance");

	a_deliver_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !waiting_q && res.valid && res.action == ACT_DELIVER)
		else $error("bitmap written outside a delivery");

endmodule

FILE: hdl/stop_and_wait_confirm_engine_core.sv
// ----------------------------------------------------------------------------
// stop_and_wait_confirm_engine_core
// Stop-and-wait delivery engine with a duplicate filter on received ids.
// Path: a taken request is registered in stage 1 with its bitmap read, then its action
//   item in the output register. Throughput: one item per cycle while evt.ready keeps up,
//   bounded by the single bitmap read-modify-write per item, with the write of one item
//   forwarded to the read of the next. Reset: session state and valid flags clear at once;
//   the seen bitmap is then swept clean, during which req.ready stays low.
// ----------------------------------------------------------------------------
module stop_and_wait_confirm_engine_core
	import swce_pkg::*;
#(
	parameter int ID_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	swce_req_if.sink           req,
	swce_evt_if.source         evt,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t               cfg;
	logic               clearing_q;
	logic [ID_BITS-1:0] clr_addr_q;
	logic               accept;
	logic               s1_valid_q;
	logic               s1_adv;
	logic               fire;
	logic [KIND_W-1:0]  kind_s1;
	logic [FTYPE_W-1:0] ftype_s1;
	logic [ID_BITS-1:0] fid_s1;
	logic               fwd_s1;
	logic [ID_BITS-1:0] req_fid;
	logic               seen_rd;
	logic               seen;
	res_t               res;
	logic               arq_we;
	logic [ID_BITS-1:0] arq_waddr;
	logic               ram_we;
	logic [ID_BITS-1:0] ram_waddr;
	logic               out_valid_q;
	logic [2:0]         out_action_q;
	logic [MSG_W-1:0]   out_id_q;

	swce_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// bitmap clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + ID_BITS'(1);
			if (clr_addr_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign req_fid   = req.frame_id[ID_BITS-1:0];
	assign fire      = s1_valid_q && (!out_valid_q || evt.ready);
	assign s1_adv    = !s1_valid_q || fire;
	assign req.ready = !clearing_q && s1_adv;
	assign accept    = req.valid && req.ready;

	assign ram_we    = clearing_q || arq_we;
	assign ram_waddr = clearing_q ? clr_addr_q : arq_waddr;

	swce_ram #(
		.WIDTH (1),
		.DEPTH (2 ** ID_BITS)
	) u_seen_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (!clearing_q),
		.re    (accept),
		.raddr (req_fid),
		.rdata (seen_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s1_valid_q <= accept;
		end
	end

	// write of the departing item lands on the same edge as the new read
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= req.kind;
			ftype_s1 <= req.frame_type;
			fid_s1   <= req_fid;
			fwd_s1   <= arq_we && (arq_waddr == req_fid);
		end
	end

	assign seen = seen_rd || fwd_s1;

	swce_arq #(
		.ID_BITS (ID_BITS)
	) u_arq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.fire       (fire),
		.kind       (kind_s1),
		.frame_type (ftype_s1),
		.frame_id   (fid_s1),
		.seen       (seen),
		.res        (res),
		.wr_en      (arq_we),
		.wr_addr    (arq_waddr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_action_q <= res.action;
			out_id_q     <= res.msg_id;
		end
	end

	assign evt.valid  = out_valid_q;
	assign evt.action = out_action_q;
	assign evt.msg_id = out_id_q;

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !accept && !s1_valid_q)
		else $error("item taken during bitmap clearing");

	a_no_write_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !arq_we)
		else $error("bitmap update during clearing");

	a_result_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !out_valid_q || evt.ready)
		else $error("result overwrites a pending item");

endmodule
